// File: hw/rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// LRU frame replacer package
// Shared constants, transaction types and link memory request type.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int unsigned MaxFrames = 64;
  localparam int unsigned FrameW    = $clog2(MaxFrames);
  localparam int unsigned CountW    = FrameW + 1;

  localparam logic [CountW-1:0] LimitReset = CountW'(MaxFrames);

  typedef enum logic [1:0] {
    OpVictim = 2'd0,
    OpPin    = 2'd1,
    OpUnpin  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StOk           = 3'd0,
    StEmpty        = 3'd1,
    StInvalid      = 3'd2,
    StPinAbsent    = 3'd3,
    StUnpinPresent = 3'd4
  } status_e;

  typedef enum logic {
    StateIdle,
    StateLink
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [FrameW-1:0] frame_num;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] victim_frame;
    logic [CountW-1:0] frame_count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [FrameW-1:0] waddr;
    logic [FrameW-1:0] wdata;
    logic [FrameW-1:0] raddr;
  } mem_req_t;

endpackage

// File: hw/rtl/lfr_link_ram.sv
// ----------------------------------------------------------------------------
// LRU frame replacer link memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfr_link_ram
  import lfr_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [FrameW-1:0] rdata_o
);

  logic [FrameW-1:0] mem_q [MaxFrames];
  logic [FrameW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lfr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU frame replacer controller
// Holds presence bits, list ends and count, and sequences link updates.
// ----------------------------------------------------------------------------
module lfr_ctrl
  import lfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              done_o,
  output rsp_t              result_o,
  output mem_req_t          newer_req_o,
  output mem_req_t          older_req_o,
  input  logic [FrameW-1:0] newer_rdata_i,
  input  logic [FrameW-1:0] older_rdata_i
);

  state_e            state_q, state_d;
  logic [MaxFrames-1:0] present_q, present_d;
  logic [FrameW-1:0] newest_q, newest_d;
  logic [FrameW-1:0] oldest_q, oldest_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] limit_q;
  logic [FrameW-1:0] frame_q, frame_d;
  logic              victim_q, victim_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;
  logic              id_valid;

  assign id_valid = {1'b0, cmd_i.frame_num} < limit_q;

  always_comb begin
    state_d   = state_q;
    present_d = present_q;
    newest_d  = newest_q;
    oldest_d  = oldest_q;
    count_d   = count_q;
    frame_d   = frame_q;
    victim_d  = victim_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    newer_req_o       = '0;
    older_req_o       = '0;
    newer_req_o.raddr = (cmd_i.operation == OpVictim) ? oldest_q : cmd_i.frame_num;
    older_req_o.raddr = newer_req_o.raddr;

    unique case (state_q)
      StateIdle: begin
        if (start) begin
          done_d             = 1'b1;
          rsp_d.status       = StOk;
          rsp_d.victim_frame = '0;
          rsp_d.frame_count  = count_q;
          frame_d            = newer_req_o.raddr;
          victim_d           = (cmd_i.operation == OpVictim);
          unique case (cmd_i.operation)
            OpVictim: begin
              if (count_q == '0) begin
                rsp_d.status = StEmpty;
              end else begin
                done_d  = 1'b0;
                state_d = StateLink;
              end
            end
            OpPin: begin
              if (!id_valid) begin
                rsp_d.status = StInvalid;
              end else if (!present_q[cmd_i.frame_num]) begin
                rsp_d.status = StPinAbsent;
              end else begin
                done_d  = 1'b0;
                state_d = StateLink;
              end
            end
            OpUnpin: begin
              if (!id_valid) begin
                rsp_d.status = StInvalid;
              end else if (present_q[cmd_i.frame_num]) begin
                rsp_d.status = StUnpinPresent;
              end else begin
                if (count_q == '0) begin
                  oldest_d = cmd_i.frame_num;
                end else begin
                  newer_req_o.we    = 1'b1;
                  newer_req_o.waddr = newest_q;
                  newer_req_o.wdata = cmd_i.frame_num;
                  older_req_o.we    = 1'b1;
                  older_req_o.waddr = cmd_i.frame_num;
                  older_req_o.wdata = newest_q;
                end
                newest_d                   = cmd_i.frame_num;
                present_d[cmd_i.frame_num] = 1'b1;
                count_d                    = count_q + 1'b1;
                rsp_d.frame_count          = count_q + 1'b1;
              end
            end
            default: begin
              rsp_d.status = StOk;
            end
          endcase
        end
      end
      StateLink: begin
        state_d = StateIdle;
        if (frame_q == oldest_q && frame_q == newest_q) begin
          oldest_d = '0;
          newest_d = '0;
        end else if (frame_q == oldest_q) begin
          oldest_d = newer_rdata_i;
        end else if (frame_q == newest_q) begin
          newest_d = older_rdata_i;
        end else begin
          newer_req_o.we    = 1'b1;
          newer_req_o.waddr = older_rdata_i;
          newer_req_o.wdata = newer_rdata_i;
          older_req_o.we    = 1'b1;
          older_req_o.waddr = newer_rdata_i;
          older_req_o.wdata = older_rdata_i;
        end
        present_d[frame_q]  = 1'b0;
        count_d             = count_q - 1'b1;
        done_d              = 1'b1;
        rsp_d.status        = StOk;
        rsp_d.victim_frame  = victim_q ? frame_q : '0;
        rsp_d.frame_count   = count_q - 1'b1;
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StateIdle;
      present_q <= '0;
      newest_q  <= '0;
      oldest_q  <= '0;
      count_q   <= '0;
      limit_q   <= LimitReset;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      newest_q  <= newest_d;
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    victim_q <= victim_d;
    rsp_q    <= rsp_d;
  end

  assign busy     = (state_q == StateLink);
  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

// File: hw/rtl/lru_frame_replacer.sv
// done_o is registered: for unpin, rejected and unused codes it rises in the cycle after acceptance.
// A successful pin or victim first passes through the link state, which uses the registered link memory read.
// One transaction per cycle is accepted while busy is low; pin and victim hold busy in the link state.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
// Reset clears presence bits, list ends and count, and sets the frame limit to 64.
// ----------------------------------------------------------------------------
// LRU frame replacer
// Least recently unpinned order of frames kept as a doubly linked list.
// ----------------------------------------------------------------------------
module lru_frame_replacer
  import lfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              done_o,
  output rsp_t              result_o
);

  mem_req_t          newer_req;
  mem_req_t          older_req;
  logic [FrameW-1:0] newer_rdata;
  logic [FrameW-1:0] older_rdata;

  lfr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .done_o       (done_o),
    .result_o     (result_o),
    .newer_req_o  (newer_req),
    .older_req_o  (older_req),
    .newer_rdata_i(newer_rdata),
    .older_rdata_i(older_rdata)
  );

  lfr_link_ram u_newer_ram (
    .clk_i  (clk_i),
    .req_i  (newer_req),
    .rdata_o(newer_rdata)
  );

  lfr_link_ram u_older_ram (
    .clk_i  (clk_i),
    .req_i  (older_req),
    .rdata_o(older_rdata)
  );

endmodule

// File: dv/lru_frame_replacer_tb.sv
// ----------------------------------------------------------------------------
// LRU frame replacer testbench
// Drives victim, pin, unpin and unused commands under several frame limits,
// predicts every response from an ordered list of evictable frames, and checks
// status, victim frame and frame count of each strobed response in order.
// ----------------------------------------------------------------------------
module lru_frame_replacer_tb;
  import lfr_pkg::*;

  localparam op_e OpUnused   = op_e'(2'd3);
  localparam int  CycleLimit = 400000;
  localparam int  TailCycles = 8;

  typedef struct {
    cmd_t cmd;
    int   hold_off;
  } queued_cmd_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              start       = 1'b0;
  logic              busy;
  cmd_t              cmd_i       = '0;
  logic              done_o;
  rsp_t              result_o;

  queued_cmd_t       cmd_backlog[$];
  queued_cmd_t       head_item;
  rsp_t              awaited_rsp[$];
  rsp_t              want;

  bit                resident[MaxFrames];
  logic [FrameW-1:0] lru_order[$];
  logic [CountW-1:0] frame_limit = LimitReset;

  int                error_count = 0;
  int                cycle_count = 0;
  int                gap_mode    = 0;

  lru_frame_replacer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("lru_frame_replacer test failed");
      $finish;
    end
  end

  function automatic rsp_t lru_apply(cmd_t c);
    rsp_t r;
    bit   in_range;
    int   pos;
    r.status       = StOk;
    r.victim_frame = '0;
    in_range       = CountW'(c.frame_num) < frame_limit;
    pos            = 0;
    case (c.operation)
      OpVictim: begin
        if (lru_order.size() == 0) begin
          r.status = StEmpty;
        end else begin
          r.victim_frame = lru_order.pop_front();
          resident[r.victim_frame] = 1'b0;
        end
      end
      OpPin: begin
        if (!in_range) begin
          r.status = StInvalid;
        end else if (!resident[c.frame_num]) begin
          r.status = StPinAbsent;
        end else begin
          foreach (lru_order[i]) begin
            if (lru_order[i] == c.frame_num) pos = i;
          end
          lru_order.delete(pos);
          resident[c.frame_num] = 1'b0;
        end
      end
      OpUnpin: begin
        if (!in_range) begin
          r.status = StInvalid;
        end else if (resident[c.frame_num]) begin
          r.status = StUnpinPresent;
        end else begin
          lru_order.push_back(c.frame_num);
          resident[c.frame_num] = 1'b1;
        end
      end
      default: ;
    endcase
    r.frame_count = CountW'(lru_order.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) awaited_rsp.push_back(lru_apply(cmd_i));
      if (!start || !busy) begin
        if (cmd_backlog.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_backlog[0].hold_off != 0) begin
          cmd_backlog[0].hold_off--;
          start <= 1'b0;
        end else begin
          head_item = cmd_backlog.pop_front();
          cmd_i <= head_item.cmd;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_rsp.size() == 0) begin
        $error("response with no transaction outstanding");
        error_count++;
      end else begin
        want = awaited_rsp.pop_front();
        if (result_o.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, result_o.status);
          error_count++;
        end
        if (result_o.victim_frame !== want.victim_frame) begin
          $error("victim_frame mismatch: expected %0d, actual %0d",
                 want.victim_frame, result_o.victim_frame);
          error_count++;
        end
        if (result_o.frame_count !== want.frame_count) begin
          $error("frame_count mismatch: expected %0d, actual %0d",
                 want.frame_count, result_o.frame_count);
          error_count++;
        end
      end
    end
  end

  function automatic int draw_gap();
    case (gap_mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  task automatic queue_cmd(op_e op, int id);
    queued_cmd_t item;
    item.cmd.operation = op;
    item.cmd.frame_num = FrameW'(id);
    item.hold_off      = draw_gap();
    cmd_backlog.push_back(item);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || start || awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_frame_limit(logic [CountW-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    frame_limit = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gap_mode = $urandom_range(0, 2);
  endtask

  task automatic queue_random(int count, int span);
    int roll;
    int id;
    op_e op;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 42) op = OpUnpin;
      else if (roll < 70) op = OpPin;
      else if (roll < 95) op = OpVictim;
      else op = OpUnused;
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MaxFrames - 1)
                                       : $urandom_range(0, span - 1);
      queue_cmd(op, id);
    end
  endtask

  task automatic queue_fill();
    int order[MaxFrames];
    int j;
    int t;
    for (int i = 0; i < MaxFrames; i++) order[i] = i;
    for (int i = MaxFrames - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < MaxFrames; i++) queue_cmd(OpUnpin, order[i]);
  endtask

  initial begin
    int issued;
    int phase;
    int count;
    int span;
    int limit;
    bit fill;
    issued = 0;
    phase  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    gap_mode = $urandom_range(0, 2);

    queue_cmd(OpVictim, 0);
    queue_cmd(OpPin, 5);
    queue_cmd(OpUnpin, 0);
    queue_cmd(OpUnpin, 63);
    queue_cmd(OpUnpin, 5);
    queue_cmd(OpUnpin, 5);
    queue_cmd(OpPin, 63);
    queue_cmd(OpUnpin, 63);
    queue_cmd(OpPin, 63);
    queue_cmd(OpPin, 0);
    queue_cmd(OpUnpin, 10);
    queue_cmd(OpVictim, 63);
    queue_cmd(OpVictim, 0);
    queue_cmd(OpVictim, 0);
    queue_cmd(OpUnused, 42);
    queue_cmd(OpUnpin, 1);
    queue_cmd(OpPin, 1);
    set_frame_limit(7'd0);
    queue_cmd(OpUnpin, 0);
    queue_cmd(OpPin, 0);
    set_frame_limit(7'd1);
    queue_cmd(OpUnpin, 0);
    queue_cmd(OpUnpin, 1);
    set_frame_limit(7'd127);
    queue_cmd(OpUnpin, 63);
    set_frame_limit(7'd3);
    queue_cmd(OpPin, 63);
    queue_cmd(OpUnpin, 63);
    queue_cmd(OpVictim, 0);
    queue_cmd(OpVictim, 0);

    while (issued < 950) begin
      fill = 1'b0;
      case (phase % 8)
        0:       begin limit = 64;  fill = 1'b1; end
        1:       limit = $urandom_range(1, 64);
        2:       begin limit = 127; fill = 1'b1; end
        3:       limit = 1;
        4:       limit = 0;
        5:       limit = $urandom_range(2, 16);
        6:       limit = 64;
        default: limit = $urandom_range(65, 127);
      endcase
      set_frame_limit(CountW'(limit));
      if (limit >= MaxFrames) begin
        case ($urandom_range(0, 2))
          0:       span = 8;
          1:       span = 24;
          default: span = MaxFrames;
        endcase
      end else begin
        span = (limit + 2 > MaxFrames) ? MaxFrames : limit + 2;
      end
      count = (limit == 0) ? 30 : $urandom_range(80, 140);
      if (fill) begin
        queue_fill();
        issued += MaxFrames;
      end
      if (issued + count > 950) count = (issued >= 950) ? 0 : 950 - issued;
      queue_random(count, span);
      issued += count;
      phase++;
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && awaited_rsp.size() == 0) begin
      $display("lru_frame_replacer test passed");
    end else begin
      $display("lru_frame_replacer test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lfr_pkg.sv
hw/rtl/lfr_link_ram.sv
hw/rtl/lfr_ctrl.sv
hw/rtl/lru_frame_replacer.sv
dv/lru_frame_replacer_tb.sv
